@@ rtl/core/fpe_pkg.sv @@
// fpe_pkg: shared types, codes, microcode rom and character tables of the format print engine
package fpe_pkg;

  localparam int unsigned CMD_W   = 3;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned DIG_W   = 4;
  localparam int unsigned DIG_N   = 16;
  localparam int unsigned LEN_W   = $clog2(DIG_N);
  localparam int unsigned UADDR_W = 3;

  // input command codes (tuser on the input side)
  localparam logic [CMD_W-1:0] CMD_FMT_BYTE = 3'd0;
  localparam logic [CMD_W-1:0] CMD_NUMBER   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_STR_BYTE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_STR_END  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_FMT_END  = 3'd4;

  // result kinds (tuser on the output side)
  localparam logic [KIND_W-1:0] KIND_CHAR  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_COUNT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_BAD   = 2'd2;

  // characters that steer the parser, and the minus sign that it prints
  localparam logic [BYTE_W-1:0] CH_PERCENT = 8'h25;
  localparam logic [BYTE_W-1:0] CH_S       = 8'h73;
  localparam logic [BYTE_W-1:0] CH_D       = 8'h64;
  localparam logic [BYTE_W-1:0] CH_X       = 8'h78;
  localparam logic [BYTE_W-1:0] CH_MINUS   = 8'h2d;

  // multiply-shift reciprocal of ten, exact for every 32-bit value
  localparam logic [WORD_W-1:0] RECIP10   = 32'hcccc_cccd;
  localparam int unsigned       RECIP_SH  = 35;
  localparam int unsigned       QUOT_W    = 2 * WORD_W - RECIP_SH;

  localparam logic [BYTE_W-1:0] DIGIT_CHARS [DIG_N] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
  };

  typedef logic [UADDR_W-1:0] uaddr_t;

  // microprogram addresses
  localparam uaddr_t UA_FETCH = 3'd0;
  localparam uaddr_t UA_END   = 3'd1;
  localparam uaddr_t UA_CHAR  = 3'd2;
  localparam uaddr_t UA_BAD   = 3'd3;
  localparam uaddr_t UA_SIGN  = 3'd4;
  localparam uaddr_t UA_MUL   = 3'd5;
  localparam uaddr_t UA_DIGIT = 3'd6;
  localparam uaddr_t UA_EMIT  = 3'd7;

  typedef enum logic [2:0] {
    OP_FETCH,
    OP_EMIT_END,
    OP_EMIT_BYTE,
    OP_EMIT_BAD,
    OP_EMIT_MINUS,
    OP_MUL,
    OP_DIGIT,
    OP_EMIT_DIGIT
  } uop_t;

  typedef enum logic [1:0] {
    JC_ALWAYS,
    JC_DISPATCH,
    JC_MORE_DIGITS,
    JC_MORE_EMIT
  } ucond_t;

  // a taken condition jumps to target; a digit step not taken falls through to
  // the emit loop, any other step goes back to fetch
  typedef struct packed {
    uop_t   op;
    ucond_t cond;
    uaddr_t target;
  } uword_t;

  function automatic uword_t ucode(input uaddr_t addr);
    uword_t w;
    case (addr)
      UA_FETCH: w = '{op: OP_FETCH,      cond: JC_DISPATCH,    target: UA_FETCH};
      UA_END:   w = '{op: OP_EMIT_END,   cond: JC_ALWAYS,      target: UA_FETCH};
      UA_CHAR:  w = '{op: OP_EMIT_BYTE,  cond: JC_ALWAYS,      target: UA_FETCH};
      UA_BAD:   w = '{op: OP_EMIT_BAD,   cond: JC_ALWAYS,      target: UA_FETCH};
      UA_SIGN:  w = '{op: OP_EMIT_MINUS, cond: JC_ALWAYS,      target: UA_MUL};
      UA_MUL:   w = '{op: OP_MUL,        cond: JC_ALWAYS,      target: UA_DIGIT};
      UA_DIGIT: w = '{op: OP_DIGIT,      cond: JC_MORE_DIGITS, target: UA_MUL};
      UA_EMIT:  w = '{op: OP_EMIT_DIGIT, cond: JC_MORE_EMIT,   target: UA_EMIT};
      default:  w = '{op: OP_FETCH,      cond: JC_ALWAYS,      target: UA_FETCH};
    endcase
    return w;
  endfunction

endpackage

@@ rtl/core/format_print_engine_top.sv @@
// format_print_engine_top: microcoded printf engine for %s, %d and %x with running count
//
//  channel | direction | tuser      | tdata (low bit up)            | tlast
//  in_     | slave     | cmd [2:0]  | data_byte, number_arg (40 b)  | -
//  out_    | master    | kind [1:0] | char_out, char_total (40 b)   | last
//
//  a literal or string character takes a fetch and an emit step; %, specifiers
//  and string end take only the fetch; a number takes a fetch, a minus sign
//  step if negative, then per digit a multiply by the reciprocal of ten and a
//  remainder step in the divide loop, and per digit out an emit step
//  rst_n is synchronous; it returns the sequencer to fetch, the parser to idle,
//  and clears the count and the output valid flag
//  a stalled output word holds the sequencer in its emit step; fetch still
//  accepts a word while the previous result waits in the output register
module format_print_engine_top
  import fpe_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  logic [CMD_W-1:0]        in_tuser,   // cmd
  input  logic [BYTE_W+WORD_W-1:0] in_tdata,  // data_byte [7:0], number_arg [39:8]
  output logic                    out_tvalid,
  input  logic                    out_tready,
  output logic [KIND_W-1:0]       out_tuser,  // kind
  output logic [BYTE_W+WORD_W-1:0] out_tdata, // char_out [7:0], char_total [39:8]
  output logic                    out_tlast   // last result of the input word
);

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_PCT,
    MODE_WAIT_D,
    MODE_WAIT_X,
    MODE_STR
  } mode_t;

  // sequencer and parser state
  uaddr_t             upc_r, upc_nxt;
  mode_t              mode_r, mode_nxt;
  logic [WORD_W-1:0]  count_r, count_nxt;

  // datapath
  logic [BYTE_W-1:0]  byte_r, byte_nxt;
  logic [WORD_W-1:0]  mag_r, mag_nxt;
  logic               hex_r, hex_nxt;
  logic [QUOT_W-1:0]  quot_r, quot_nxt;
  logic [DIG_W-1:0]   digs_r [DIG_N];
  logic [LEN_W-1:0]   len_r, len_nxt;
  logic               dig_we;
  logic [DIG_W-1:0]   dig_wdata;

  // output register
  logic               ovalid_r, ovalid_nxt;
  logic [KIND_W-1:0]  okind_r, okind_nxt;
  logic [BYTE_W-1:0]  ochar_r, ochar_nxt;
  logic [WORD_W-1:0]  ototal_r, ototal_nxt;
  logic               olast_r, olast_nxt;

  uword_t             uw;
  logic [CMD_W-1:0]   in_cmd;
  logic [BYTE_W-1:0]  in_byte;
  logic [WORD_W-1:0]  in_arg;
  uaddr_t             disp_target;
  mode_t              disp_mode;
  logic               disp_hex;
  logic [WORD_W-1:0]  disp_mag;
  logic               out_free;
  logic [WORD_W-1:0]  count_inc;
  logic [2*WORD_W-1:0] prod;
  logic [WORD_W-1:0]  quot_ext;
  logic [WORD_W-1:0]  rem_full;
  logic [LEN_W-1:0]   rd_idx;
  logic [WORD_W-1:0]  mag_step;
  logic               jump_ok;

  assign uw       = ucode(upc_r);
  assign in_cmd   = in_tuser;
  assign in_byte  = in_tdata[BYTE_W-1:0];
  assign in_arg   = in_tdata[BYTE_W+WORD_W-1:BYTE_W];
  assign out_free = !ovalid_r || out_tready;
  assign in_tready = (uw.op == OP_FETCH);

  // saturating increment of the printed count
  assign count_inc = (count_r == '1) ? count_r : count_r + 1'b1;

  // divide by ten: multiply here, remainder in the digit step
  assign prod     = mag_r * RECIP10;
  assign quot_ext = {{(WORD_W-QUOT_W){1'b0}}, quot_r};
  assign rem_full = mag_r - ((quot_ext << 3) + (quot_ext << 1));
  assign rd_idx   = len_r - 1'b1;

  // magnitude left after the current digit is taken off
  assign mag_step = hex_r ? (mag_r >> DIG_W) : quot_ext;

  // jump condition selected by the control word
  always_comb begin
    case (uw.cond)
      JC_MORE_DIGITS: jump_ok = (mag_step != '0);
      JC_MORE_EMIT:   jump_ok = (len_r != LEN_W'(1));
      default:        jump_ok = 1'b1;
    endcase
  end

  // entry decode: where the fetched word goes and what the parser turns into
  always_comb begin
    disp_target = UA_BAD;
    disp_mode   = mode_r;
    disp_hex    = 1'b0;
    disp_mag    = in_arg;
    if (in_cmd == CMD_FMT_END ||
        (in_cmd == CMD_FMT_BYTE && in_byte == '0 &&
         (mode_r == MODE_IDLE || mode_r == MODE_PCT))) begin
      disp_target = UA_END;
      disp_mode   = MODE_IDLE;
    end else begin
      case (in_cmd)
        CMD_FMT_BYTE: begin
          if (mode_r == MODE_IDLE) begin
            if (in_byte == CH_PERCENT) begin
              disp_target = UA_FETCH;
              disp_mode   = MODE_PCT;
            end else begin
              disp_target = UA_CHAR;
            end
          end else if (mode_r == MODE_PCT) begin
            disp_target = UA_FETCH;
            case (in_byte)
              CH_S:    disp_mode = MODE_STR;
              CH_D:    disp_mode = MODE_WAIT_D;
              CH_X:    disp_mode = MODE_WAIT_X;
              default: disp_mode = MODE_IDLE;
            endcase
          end
        end
        CMD_NUMBER: begin
          if (mode_r == MODE_WAIT_D) begin
            disp_mode = MODE_IDLE;
            if (in_arg[WORD_W-1]) begin
              disp_target = UA_SIGN;
              disp_mag    = '0 - in_arg;
            end else begin
              disp_target = UA_MUL;
            end
          end else if (mode_r == MODE_WAIT_X) begin
            disp_mode   = MODE_IDLE;
            disp_target = UA_MUL;
            disp_hex    = 1'b1;
          end
        end
        CMD_STR_BYTE, CMD_STR_END: begin
          if (mode_r == MODE_STR) begin
            if (in_cmd == CMD_STR_END || in_byte == '0) begin
              disp_target = UA_FETCH;
              disp_mode   = MODE_IDLE;
            end else begin
              disp_target = UA_CHAR;
            end
          end
        end
        default: disp_target = UA_BAD;
      endcase
    end
  end

  // datapath driven by the current control word
  always_comb begin
    upc_nxt    = upc_r;
    mode_nxt   = mode_r;
    count_nxt  = count_r;
    byte_nxt   = byte_r;
    mag_nxt    = mag_r;
    hex_nxt    = hex_r;
    quot_nxt   = quot_r;
    len_nxt    = len_r;
    dig_we     = 1'b0;
    dig_wdata  = hex_r ? mag_r[DIG_W-1:0] : rem_full[DIG_W-1:0];
    ovalid_nxt = ovalid_r && !out_tready;
    okind_nxt  = okind_r;
    ochar_nxt  = ochar_r;
    ototal_nxt = ototal_r;
    olast_nxt  = olast_r;

    case (uw.op)
      OP_FETCH: begin
        if (in_tvalid) begin
          upc_nxt  = disp_target;
          mode_nxt = disp_mode;
          byte_nxt = in_byte;
          mag_nxt  = disp_mag;
          hex_nxt  = disp_hex;
          len_nxt  = '0;
        end
      end
      OP_EMIT_END: begin
        if (out_free) begin
          ovalid_nxt = 1'b1;
          okind_nxt  = KIND_COUNT;
          ochar_nxt  = '0;
          ototal_nxt = count_r;
          olast_nxt  = 1'b1;
          count_nxt  = '0;
          upc_nxt    = uw.target;
        end
      end
      OP_EMIT_BYTE, OP_EMIT_MINUS: begin
        if (out_free) begin
          ovalid_nxt = 1'b1;
          okind_nxt  = KIND_CHAR;
          ochar_nxt  = (uw.op == OP_EMIT_MINUS) ? CH_MINUS : byte_r;
          ototal_nxt = count_inc;
          olast_nxt  = (uw.op == OP_EMIT_BYTE);
          count_nxt  = count_inc;
          upc_nxt    = uw.target;
        end
      end
      OP_EMIT_BAD: begin
        if (out_free) begin
          ovalid_nxt = 1'b1;
          okind_nxt  = KIND_BAD;
          ochar_nxt  = '0;
          ototal_nxt = count_r;
          olast_nxt  = 1'b1;
          upc_nxt    = uw.target;
        end
      end
      OP_MUL: begin
        quot_nxt = prod[2*WORD_W-1:RECIP_SH];
        upc_nxt  = uw.target;
      end
      OP_DIGIT: begin
        dig_we  = 1'b1;
        len_nxt = len_r + 1'b1;
        mag_nxt = mag_step;
        upc_nxt = jump_ok ? uw.target : UA_EMIT;
      end
      OP_EMIT_DIGIT: begin
        if (out_free) begin
          ovalid_nxt = 1'b1;
          okind_nxt  = KIND_CHAR;
          ochar_nxt  = DIGIT_CHARS[digs_r[rd_idx]];
          ototal_nxt = count_inc;
          olast_nxt  = (len_r == LEN_W'(1));
          count_nxt  = count_inc;
          len_nxt    = rd_idx;
          upc_nxt    = jump_ok ? uw.target : UA_FETCH;
        end
      end
      default: upc_nxt = UA_FETCH;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r    <= UA_FETCH;
      mode_r   <= MODE_IDLE;
      count_r  <= '0;
      len_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      upc_r    <= upc_nxt;
      mode_r   <= mode_nxt;
      count_r  <= count_nxt;
      len_r    <= len_nxt;
      ovalid_r <= ovalid_nxt;
    end
    byte_r   <= byte_nxt;
    mag_r    <= mag_nxt;
    hex_r    <= hex_nxt;
    quot_r   <= quot_nxt;
    okind_r  <= okind_nxt;
    ochar_r  <= ochar_nxt;
    ototal_r <= ototal_nxt;
    olast_r  <= olast_nxt;
    if (dig_we) begin
      digs_r[len_r] <= dig_wdata;
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tuser  = okind_r;
  assign out_tdata  = {ototal_r, ochar_r};
  assign out_tlast  = olast_r;

  // a 32-bit number never has more than ten decimal or eight hex digits
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LEN_W'(10))
    else $error("digit buffer overrun");

  // the digit emit step always has a digit left to send
  a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    upc_r == UA_EMIT |-> len_r != '0)
    else $error("digit emit with empty buffer");

  // a format end goes straight to the count emit step
  a_fend_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser == CMD_FMT_END) |=> upc_r == UA_END)
    else $error("format end not dispatched");

  // a count or error result always closes its input word
  a_kind_last: assert property (@(posedge clk) disable iff (!rst_n)
    (ovalid_r && (okind_r == KIND_COUNT || okind_r == KIND_BAD)) |-> olast_r)
    else $error("count or error result without last");

  // after a count result the running count starts again from zero
  a_count_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (upc_r == UA_END && out_free) |=> count_r == '0)
    else $error("count not cleared at format end");

endmodule
